FILE: rtl/pkcspad_pkg.sv
// Shared types, constants and lookup functions of the PKCS#1 v1.5 padding block.
`timescale 1ns / 1ps
package pkcspad_pkg;

   localparam int MAX_BLOCK_BYTES_DEF = 512;

   localparam int BYTE_W      = 8;
   localparam int KIND_W      = 3;
   localparam int LEN_CFG_W   = 10;
   localparam int CALC_W      = 11;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 10;
   localparam int PREFIX_MAX  = 19;
   localparam int PREFIX_IDX_W = 5;
   localparam int HASH_KINDS  = 7;
   localparam int LEN_W       = 7;

   localparam logic [CSR_IDX_W-1:0] CSR_HASH_KIND   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_BYTES = 1'd1;

   localparam logic [KIND_W-1:0]    KIND_SHA1       = 3'd0;
   localparam logic [KIND_W-1:0]    KIND_SHA224     = 3'd1;
   localparam logic [KIND_W-1:0]    KIND_SHA256     = 3'd2;
   localparam logic [KIND_W-1:0]    KIND_SHA384     = 3'd3;
   localparam logic [KIND_W-1:0]    KIND_SHA512     = 3'd4;
   localparam logic [KIND_W-1:0]    KIND_SHA512_224 = 3'd5;
   localparam logic [KIND_W-1:0]    KIND_SHA512_256 = 3'd6;

   localparam logic [KIND_W-1:0]    KIND_MAX        = KIND_SHA512_256;
   localparam logic [KIND_W-1:0]    KIND_RESET      = KIND_SHA256;
   localparam logic [LEN_CFG_W-1:0] BLOCK_RESET     = 10'd256;
   localparam logic [CALC_W-1:0]    MIN_LEN         = 11'd16;
   localparam logic [CALC_W-1:0]    FRAME_BYTES     = 11'd11;

   localparam logic [BYTE_W-1:0] BYTE_ZERO = 8'h00;
   localparam logic [BYTE_W-1:0] BYTE_ONE  = 8'h01;
   localparam logic [BYTE_W-1:0] BYTE_PAD  = 8'hFF;

   localparam logic [0:HASH_KINDS-1][0:PREFIX_MAX-1][BYTE_W-1:0] PREFIX_ROM = '{
      '{8'h30, 8'h21, 8'h30, 8'h09, 8'h06, 8'h05, 8'h2b, 8'h0e, 8'h03, 8'h02,
        8'h1a, 8'h05, 8'h00, 8'h04, 8'h14, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h30, 8'h2d, 8'h30, 8'h0d, 8'h06, 8'h09, 8'h60, 8'h86, 8'h48, 8'h01,
        8'h65, 8'h03, 8'h04, 8'h02, 8'h04, 8'h05, 8'h00, 8'h04, 8'h1c},
      '{8'h30, 8'h31, 8'h30, 8'h0d, 8'h06, 8'h09, 8'h60, 8'h86, 8'h48, 8'h01,
        8'h65, 8'h03, 8'h04, 8'h02, 8'h01, 8'h05, 8'h00, 8'h04, 8'h20},
      '{8'h30, 8'h41, 8'h30, 8'h0d, 8'h06, 8'h09, 8'h60, 8'h86, 8'h48, 8'h01,
        8'h65, 8'h03, 8'h04, 8'h02, 8'h02, 8'h05, 8'h00, 8'h04, 8'h30},
      '{8'h30, 8'h51, 8'h30, 8'h0d, 8'h06, 8'h09, 8'h60, 8'h86, 8'h48, 8'h01,
        8'h65, 8'h03, 8'h04, 8'h02, 8'h03, 8'h05, 8'h00, 8'h04, 8'h40},
      '{8'h30, 8'h2d, 8'h30, 8'h0d, 8'h06, 8'h09, 8'h60, 8'h86, 8'h48, 8'h01,
        8'h65, 8'h03, 8'h04, 8'h02, 8'h05, 8'h05, 8'h00, 8'h04, 8'h1c},
      '{8'h30, 8'h31, 8'h30, 8'h0d, 8'h06, 8'h09, 8'h60, 8'h86, 8'h48, 8'h01,
        8'h65, 8'h03, 8'h04, 8'h02, 8'h06, 8'h05, 8'h00, 8'h04, 8'h20}
   };

   typedef struct packed {
      logic              action;
      logic [BYTE_W-1:0] hash_byte;
      logic [BYTE_W-1:0] block_byte;
   } req_item_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              match_ok;
      logic              last_byte;
      logic              length_error;
   } rsp_item_type;

   function automatic logic [LEN_W-1:0] prefix_len(input logic [KIND_W-1:0] kind);
      logic [LEN_W-1:0] n;
      case (kind)
         KIND_SHA1: n = 7'd15;
         default:   n = 7'd19;
      endcase
      return n;
   endfunction

   function automatic logic [LEN_W-1:0] digest_len(input logic [KIND_W-1:0] kind);
      logic [LEN_W-1:0] n;
      case (kind)
         KIND_SHA1:       n = 7'd20;
         KIND_SHA224:     n = 7'd28;
         KIND_SHA256:     n = 7'd32;
         KIND_SHA384:     n = 7'd48;
         KIND_SHA512:     n = 7'd64;
         KIND_SHA512_224: n = 7'd28;
         default:         n = 7'd32;
      endcase
      return n;
   endfunction

   function automatic logic [BYTE_W-1:0] prefix_byte(input logic [KIND_W-1:0] kind,
                                                     input logic [PREFIX_IDX_W-1:0] idx);
      logic [BYTE_W-1:0] b;
      b = BYTE_ZERO;
      if (kind <= KIND_MAX && idx < PREFIX_IDX_W'(PREFIX_MAX)) begin
         b = PREFIX_ROM[kind][idx];
      end
      return b;
   endfunction

endpackage

FILE: rtl/pkcs1_v15_signature_padding_top.sv
// Top level of the PKCS#1 v1.5 signature block encoder and checker.
// One request per byte position of the block; one response per request, presented on rsp_valid
// once it has passed the request register and the response register; a response-side stall
// holds it. A new byte is accepted every cycle unless the response side stalls: the position
// counter, its bound compare and the expected-byte select sit in one stage between the request
// register and the response register. Check mode is chosen by req_action at the first byte of a
// block; rsp_match_ok at rsp_last_byte is the verdict. Write the configuration registers only
// while no block is in flight; they take effect on the next request.
`timescale 1ns / 1ps
module pkcs1_v15_signature_padding_top #(
   parameter int MAX_BLOCK_BYTES = pkcspad_pkg::MAX_BLOCK_BYTES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_action,
   input  logic [pkcspad_pkg::BYTE_W-1:0]      req_hash_byte,
   input  logic [pkcspad_pkg::BYTE_W-1:0]      req_block_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [pkcspad_pkg::BYTE_W-1:0]      rsp_out_byte,
   output logic                                rsp_match_ok,
   output logic                                rsp_last_byte,
   output logic                                rsp_length_error,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pkcspad_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pkcspad_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import pkcspad_pkg::*;

   logic [KIND_W-1:0]    hash_kind_ff, hash_kind_in;
   logic [LEN_CFG_W-1:0] block_bytes_ff, block_bytes_in;

   req_item_type req_item, item;
   rsp_item_type result, rsp_item;
   logic         item_valid, advance, fire;

   assign csr_ready = 1'b1;

   always_comb begin
      hash_kind_in   = hash_kind_ff;
      block_bytes_in = block_bytes_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_HASH_KIND:   hash_kind_in   = csr_wdata[KIND_W-1:0];
            CSR_BLOCK_BYTES: block_bytes_in = csr_wdata[LEN_CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_kind_ff   <= KIND_RESET;
         block_bytes_ff <= BLOCK_RESET;
      end else begin
         hash_kind_ff   <= hash_kind_in;
         block_bytes_ff <= block_bytes_in;
      end
   end

   assign req_item.action     = req_action;
   assign req_item.hash_byte  = req_hash_byte;
   assign req_item.block_byte = req_block_byte;

   pkcspad_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   assign fire = item_valid && advance;

   pkcspad_core #(
      .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .item        (item),
      .hash_kind   (hash_kind_ff),
      .block_bytes (block_bytes_ff),
      .result      (result)
   );

   pkcspad_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .result    (result),
      .advance   (advance),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   assign rsp_out_byte     = rsp_item.out_byte;
   assign rsp_match_ok     = rsp_item.match_ok;
   assign rsp_last_byte    = rsp_item.last_byte;
   assign rsp_length_error = rsp_item.length_error;

endmodule

FILE: rtl/pkcspad_in_stage.sv
// Input register stage of the padding block with request stall generation.
`timescale 1ns / 1ps
module pkcspad_in_stage (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  pkcspad_pkg::req_item_type  req_item,
   input  logic                       advance,
   output logic                       item_valid,
   output pkcspad_pkg::req_item_type  item
);
   import pkcspad_pkg::*;

   logic         valid_ff, valid_in;
   req_item_type item_ff, item_in;
   logic         take;

   assign req_stall = valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (take) begin
         valid_in = 1'b1;
         item_in  = req_item;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

FILE: rtl/pkcspad_core.sv
// Position counter, running match state and expected-byte logic of the padding block.
`timescale 1ns / 1ps
module pkcspad_core #(
   parameter int MAX_BLOCK_BYTES = pkcspad_pkg::MAX_BLOCK_BYTES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 fire,
   input  pkcspad_pkg::req_item_type            item,
   input  logic [pkcspad_pkg::KIND_W-1:0]       hash_kind,
   input  logic [pkcspad_pkg::LEN_CFG_W-1:0]    block_bytes,
   output pkcspad_pkg::rsp_item_type            result
);
   import pkcspad_pkg::*;

   localparam int POS_W = $clog2(MAX_BLOCK_BYTES);
   localparam logic [CALC_W-1:0] MAX_LEN = CALC_W'(MAX_BLOCK_BYTES);
   localparam logic [CALC_W-1:0] ONE     = CALC_W'(1);

   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              match_ff, match_in;
   logic              action_ff, action_in;

   logic [KIND_W-1:0] kind;
   logic [CALC_W-1:0] bb_ext, len, d, h, p_raw, p, sep, hash_start;
   logic [CALC_W-1:0] rom_off;
   logic              first, short_blk, last, mismatch, match_base;
   logic [BYTE_W-1:0] expect_byte;

   always_comb begin
      kind   = (hash_kind > KIND_MAX) ? KIND_MAX : hash_kind;
      bb_ext = CALC_W'(block_bytes);
      if (bb_ext < MIN_LEN) begin
         len = MIN_LEN;
      end else if (bb_ext > MAX_LEN) begin
         len = MAX_LEN;
      end else begin
         len = bb_ext;
      end
      d          = CALC_W'(prefix_len(kind));
      h          = CALC_W'(digest_len(kind));
      short_blk  = len < (d + h + FRAME_BYTES);
      first      = (pos_ff == '0);
      p_raw      = CALC_W'(pos_ff);
      p          = (p_raw >= len) ? (len - ONE) : p_raw;
      last       = (p == len - ONE);
      sep        = len - h - d - ONE;
      hash_start = len - h;
      rom_off    = p - sep - ONE;

      if (short_blk) begin
         expect_byte = BYTE_ZERO;
      end else if (p == '0) begin
         expect_byte = BYTE_ZERO;
      end else if (p == ONE) begin
         expect_byte = BYTE_ONE;
      end else if (p < sep) begin
         expect_byte = BYTE_PAD;
      end else if (p == sep) begin
         expect_byte = BYTE_ZERO;
      end else if (p < hash_start) begin
         expect_byte = prefix_byte(kind, rom_off[PREFIX_IDX_W-1:0]);
      end else begin
         expect_byte = item.hash_byte;
      end

      action_in  = first ? item.action : action_ff;
      match_base = first ? 1'b1 : match_ff;
      mismatch   = action_in && (item.block_byte != expect_byte);
      match_in   = short_blk ? 1'b0 : (mismatch ? 1'b0 : match_base);
      pos_in     = last ? '0 : POS_W'(p + ONE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         match_ff  <= 1'b1;
         action_ff <= 1'b0;
      end else if (fire) begin
         pos_ff    <= pos_in;
         match_ff  <= match_in;
         action_ff <= action_in;
      end
   end

   assign result.out_byte     = expect_byte;
   assign result.match_ok     = match_in;
   assign result.last_byte    = last;
   assign result.length_error = short_blk;

endmodule

FILE: rtl/pkcspad_out_stage.sv
// Result register stage of the padding block.
`timescale 1ns / 1ps
module pkcspad_out_stage (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      fire,
   input  pkcspad_pkg::rsp_item_type result,
   output logic                      advance,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output pkcspad_pkg::rsp_item_type rsp_item
);
   import pkcspad_pkg::*;

   logic         valid_ff, valid_in;
   rsp_item_type item_ff, item_in;

   assign advance = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (fire) begin
         valid_in = 1'b1;
         item_in  = result;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule

FILE: rtl/pkcspad_checker.sv
// Port-level checker of the padding block and its bind to the top level.
`timescale 1ns / 1ps
module pkcspad_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [pkcspad_pkg::BYTE_W-1:0]      rsp_out_byte,
   input logic                                rsp_match_ok,
   input logic                                rsp_last_byte,
   input logic                                rsp_length_error
);

   a_rsp_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_out_byte) && $stable(rsp_match_ok)
                                 && $stable(rsp_last_byte) && $stable(rsp_length_error))
      else $error("stalled response changed");

   a_len_err_no_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_length_error |-> !rsp_match_ok)
      else $error("match reported on a short block");

   a_no_stall_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with empty response register");

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid straight after reset");

endmodule

bind pkcs1_v15_signature_padding_top pkcspad_checker u_checker (.*);

FILE: bench/pkcs1_v15_signature_padding_top_tb.sv
// Self-checking bench for the PKCS#1 v1.5 signature padding block, encode and check modes.
`timescale 1ns / 1ps
module pkcs1_v15_signature_padding_top_tb;
   import pkcspad_pkg::*;

   localparam int PAD_MAX        = MAX_BLOCK_BYTES_DEF;
   localparam int FRAME_OVERHEAD = 11;
   localparam int RANDOM_ITEMS   = 800;
   localparam int QUIET_FROM     = 650;
   localparam int SETTLE_CYCLES  = 8;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int HOLD_OFF_ITEMS = 40;
   localparam int DRAIN_LIMIT    = 5000;

   localparam logic [0:6][6:0] INFO_BYTES   = '{7'd15, 7'd19, 7'd19, 7'd19, 7'd19, 7'd19, 7'd19};
   localparam logic [0:6][6:0] DIGEST_BYTES = '{7'd20, 7'd28, 7'd32, 7'd48, 7'd64, 7'd28, 7'd32};
   localparam logic [0:6][0:18][7:0] DIGEST_INFO = '{
      '{8'h30, 8'h21, 8'h30, 8'h09, 8'h06, 8'h05, 8'h2b, 8'h0e, 8'h03, 8'h02,
        8'h1a, 8'h05, 8'h00, 8'h04, 8'h14, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h30, 8'h2d, 8'h30, 8'h0d, 8'h06, 8'h09, 8'h60, 8'h86, 8'h48, 8'h01,
        8'h65, 8'h03, 8'h04, 8'h02, 8'h04, 8'h05, 8'h00, 8'h04, 8'h1c},
      '{8'h30, 8'h31, 8'h30, 8'h0d, 8'h06, 8'h09, 8'h60, 8'h86, 8'h48, 8'h01,
        8'h65, 8'h03, 8'h04, 8'h02, 8'h01, 8'h05, 8'h00, 8'h04, 8'h20},
      '{8'h30, 8'h41, 8'h30, 8'h0d, 8'h06, 8'h09, 8'h60, 8'h86, 8'h48, 8'h01,
        8'h65, 8'h03, 8'h04, 8'h02, 8'h02, 8'h05, 8'h00, 8'h04, 8'h30},
      '{8'h30, 8'h51, 8'h30, 8'h0d, 8'h06, 8'h09, 8'h60, 8'h86, 8'h48, 8'h01,
        8'h65, 8'h03, 8'h04, 8'h02, 8'h03, 8'h05, 8'h00, 8'h04, 8'h40},
      '{8'h30, 8'h2d, 8'h30, 8'h0d, 8'h06, 8'h09, 8'h60, 8'h86, 8'h48, 8'h01,
        8'h65, 8'h03, 8'h04, 8'h02, 8'h05, 8'h05, 8'h00, 8'h04, 8'h1c},
      '{8'h30, 8'h31, 8'h30, 8'h0d, 8'h06, 8'h09, 8'h60, 8'h86, 8'h48, 8'h01,
        8'h65, 8'h03, 8'h04, 8'h02, 8'h06, 8'h05, 8'h00, 8'h04, 8'h20}
   };

   typedef enum logic {ROW_REQUEST, ROW_WRITE} row_kind_type;
   typedef enum logic [1:0] {SPOIL_NONE, SPOIL_SPARSE, SPOIL_NOISE} spoil_type;

   typedef struct packed {
      row_kind_type           kind;
      logic [CSR_IDX_W-1:0]   reg_idx;
      logic [CSR_DATA_W-1:0]  reg_data;
      logic                   action;
      logic [BYTE_W-1:0]      hash_byte;
      logic [BYTE_W-1:0]      block_byte;
      logic                   follow;
      logic [3:0]             reps;
      logic                   typed;
      rsp_item_type           want;
   } pad_case_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic                   req_action;
   logic [BYTE_W-1:0]      req_hash_byte;
   logic [BYTE_W-1:0]      req_block_byte;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [BYTE_W-1:0]      rsp_out_byte;
   logic                   rsp_match_ok;
   logic                   rsp_last_byte;
   logic                   rsp_length_error;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   logic [KIND_W-1:0]      cfg_kind;
   logic [LEN_CFG_W-1:0]   cfg_len;
   logic [LEN_CFG_W-1:0]   pad_position;
   logic                   pad_match;
   logic                   pad_action;

   rsp_item_type           pending_rsp [$];
   int                     mismatch_count = 0;
   int                     random_items = 0;
   bit                     quiet_tail = 1'b0;
   bit                     hold_off_req = 1'b0;
   bit                     hold_off_active = 1'b0;
   bit                     send_calm = 1'b1;
   int                     send_stretch = 0;
   spoil_type              block_spoil = SPOIL_NONE;

   // columns: kind, register, data, action, hash, block, follow, reps, typed, response
   pad_case_type directed_cases [0:21] = '{
      '{ROW_REQUEST, CSR_HASH_KIND, 10'd0, 1'b0, 8'hFF, 8'h00, 1'b0, 4'd1, 1'b1,
        '{8'h00, 1'b1, 1'b0, 1'b0}},
      '{ROW_REQUEST, CSR_HASH_KIND, 10'd0, 1'b1, 8'h00, 8'hFF, 1'b0, 4'd1, 1'b1,
        '{8'h01, 1'b1, 1'b0, 1'b0}},
      '{ROW_REQUEST, CSR_HASH_KIND, 10'd0, 1'b0, 8'h5A, 8'hA5, 1'b0, 4'd1, 1'b1,
        '{8'hFF, 1'b1, 1'b0, 1'b0}},
      '{ROW_WRITE, CSR_HASH_KIND, 10'h3F8, 1'b0, 8'h00, 8'h00, 1'b0, 4'd0, 1'b0, '0},
      '{ROW_REQUEST, CSR_HASH_KIND, 10'd0, 1'b0, 8'h80, 8'h7F, 1'b0, 4'd1, 1'b0, '0},
      '{ROW_WRITE, CSR_BLOCK_BYTES, 10'd16, 1'b0, 8'h00, 8'h00, 1'b0, 4'd0, 1'b0, '0},
      '{ROW_REQUEST, CSR_HASH_KIND, 10'd0, 1'b1, 8'hFF, 8'hFF, 1'b0, 4'd2, 1'b1,
        '{8'h00, 1'b0, 1'b0, 1'b1}},
      '{ROW_WRITE, CSR_BLOCK_BYTES, 10'd0, 1'b0, 8'h00, 8'h00, 1'b0, 4'd0, 1'b0, '0},
      '{ROW_REQUEST, CSR_HASH_KIND, 10'd0, 1'b0, 8'h00, 8'h00, 1'b0, 4'd1, 1'b1,
        '{8'h00, 1'b0, 1'b0, 1'b1}},
      '{ROW_WRITE, CSR_BLOCK_BYTES, 10'h3FF, 1'b0, 8'h00, 8'h00, 1'b0, 4'd0, 1'b0, '0},
      '{ROW_REQUEST, CSR_HASH_KIND, 10'd0, 1'b1, 8'hC3, 8'h00, 1'b1, 4'd2, 1'b0, '0},
      '{ROW_WRITE, CSR_HASH_KIND, 10'h3FF, 1'b0, 8'h00, 8'h00, 1'b0, 4'd0, 1'b0, '0},
      '{ROW_WRITE, CSR_BLOCK_BYTES, 10'd16, 1'b0, 8'h00, 8'h00, 1'b0, 4'd0, 1'b0, '0},
      '{ROW_REQUEST, CSR_HASH_KIND, 10'd0, 1'b0, 8'hFF, 8'h00, 1'b0, 4'd6, 1'b1,
        '{8'h00, 1'b0, 1'b0, 1'b1}},
      '{ROW_REQUEST, CSR_HASH_KIND, 10'd0, 1'b1, 8'h00, 8'hFF, 1'b0, 4'd1, 1'b1,
        '{8'h00, 1'b0, 1'b1, 1'b1}},
      '{ROW_WRITE, CSR_BLOCK_BYTES, 10'd62, 1'b0, 8'h00, 8'h00, 1'b0, 4'd0, 1'b0, '0},
      '{ROW_REQUEST, CSR_HASH_KIND, 10'd0, 1'b1, 8'h11, 8'h00, 1'b0, 4'd1, 1'b1,
        '{8'h00, 1'b1, 1'b0, 1'b0}},
      '{ROW_REQUEST, CSR_HASH_KIND, 10'd0, 1'b1, 8'h22, 8'h02, 1'b0, 4'd1, 1'b1,
        '{8'h01, 1'b0, 1'b0, 1'b0}},
      '{ROW_REQUEST, CSR_HASH_KIND, 10'd0, 1'b0, 8'h33, 8'h00, 1'b1, 4'd2, 1'b0, '0},
      '{ROW_WRITE, CSR_HASH_KIND, 10'd4, 1'b0, 8'h00, 8'h00, 1'b0, 4'd0, 1'b0, '0},
      '{ROW_WRITE, CSR_BLOCK_BYTES, 10'd93, 1'b0, 8'h00, 8'h00, 1'b0, 4'd0, 1'b0, '0},
      '{ROW_REQUEST, CSR_HASH_KIND, 10'd0, 1'b1, 8'h44, 8'h44, 1'b0, 4'd1, 1'b1,
        '{8'h00, 1'b0, 1'b0, 1'b1}}
   };

   pkcs1_v15_signature_padding_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_hash_byte    (req_hash_byte),
      .req_block_byte   (req_block_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_match_ok     (rsp_match_ok),
      .rsp_last_byte    (rsp_last_byte),
      .rsp_length_error (rsp_length_error),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #2 clock = ~clock;

   function automatic int eff_kind(input logic [KIND_W-1:0] k);
      return (k > KIND_MAX) ? int'(KIND_MAX) : int'(k);
   endfunction

   function automatic int frame_min(input logic [KIND_W-1:0] k);
      return int'(INFO_BYTES[eff_kind(k)]) + int'(DIGEST_BYTES[eff_kind(k)]) + FRAME_OVERHEAD;
   endfunction

   function automatic int pad_len();
      int n;
      n = int'(cfg_len);
      if (n < 16) n = 16;
      if (n > PAD_MAX) n = PAD_MAX;
      return n;
   endfunction

   function automatic bit pad_short();
      return pad_len() < frame_min(cfg_kind);
   endfunction

   function automatic int pad_pos();
      int p;
      p = int'(pad_position);
      if (p >= pad_len()) p = pad_len() - 1;
      return p;
   endfunction

   function automatic logic [BYTE_W-1:0] frame_byte(input int p, input logic [BYTE_W-1:0] hb);
      int k;
      int len;
      int h;
      int sep;
      logic [BYTE_W-1:0] b;
      k   = eff_kind(cfg_kind);
      len = pad_len();
      h   = int'(DIGEST_BYTES[k]);
      sep = len - h - int'(INFO_BYTES[k]) - 1;
      if (pad_short()) b = 8'h00;
      else if (p == 0) b = 8'h00;
      else if (p == 1) b = 8'h01;
      else if (p < sep) b = 8'hFF;
      else if (p == sep) b = 8'h00;
      else if (p < len - h) b = DIGEST_INFO[k][(p - sep - 1) % 19];
      else b = hb;
      return b;
   endfunction

   function automatic rsp_item_type advance_padding(input req_item_type it);
      rsp_item_type r;
      int p;
      if (pad_position == '0) begin
         pad_action = it.action;
         pad_match  = 1'b1;
      end
      p = pad_pos();
      r.out_byte = frame_byte(p, it.hash_byte);
      if (pad_short()) pad_match = 1'b0;
      else if (pad_action && it.block_byte != r.out_byte) pad_match = 1'b0;
      r.match_ok     = pad_match;
      r.last_byte    = (p == pad_len() - 1);
      r.length_error = pad_short();
      pad_position   = r.last_byte ? '0 : LEN_CFG_W'(p + 1);
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      if (mismatch_count < 50) $display("%0t: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic offer_request(input req_item_type item, input bit typed,
                                input rsp_item_type want);
      rsp_item_type predicted;
      if (send_stretch == 0) begin
         send_calm    = $urandom_range(0, 1);
         send_stretch = $urandom_range(20, 100);
      end else begin
         send_stretch--;
      end
      if (!quiet_tail && !hold_off_active && !send_calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_action     <= item.action;
      req_hash_byte  <= item.hash_byte;
      req_block_byte <= item.block_byte;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = advance_padding(item);
      pending_rsp.push_back(typed ? want : predicted);
   endtask

   task automatic settle_block();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_HASH_KIND) cfg_kind = data[KIND_W-1:0];
      else cfg_len = data;
      @(posedge clock);
   endtask

   always @(posedge clock) begin : rsp_check
      rsp_item_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_out_byte !== want.out_byte || rsp_match_ok !== want.match_ok ||
                rsp_last_byte !== want.last_byte || rsp_length_error !== want.length_error) begin
               report_mismatch($sformatf(
                  "byte %h ok %b last %b lenerr %b, want byte %h ok %b last %b lenerr %b",
                  rsp_out_byte, rsp_match_ok, rsp_last_byte, rsp_length_error,
                  want.out_byte, want.match_ok, want.last_byte, want.length_error));
            end
         end
      end
   end

   initial begin : rsp_backpressure
      int n;
      bit calm;
      int stretch;
      calm    = 1'b1;
      stretch = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req    = 1'b0;
            hold_off_active = 1'b1;
            rsp_stall <= 1'b1;
            for (n = 0; n < HOLD_OFF_CYCLES; n++) @(posedge clock);
            rsp_stall <= 1'b0;
            hold_off_active = 1'b0;
         end else if (!quiet_tail && !calm && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         if (stretch == 0) begin
            calm    = $urandom_range(0, 1);
            stretch = $urandom_range(20, 120);
         end else begin
            stretch--;
         end
      end
   end

   initial begin : stimulus
      pad_case_type            row;
      req_item_type            item;
      logic [BYTE_W-1:0]       good;
      logic [CSR_DATA_W-1:0]   kind_data;
      int                      new_len;
      int                      blk;
      int                      n;
      int                      i;
      int                      j;
      int                      phase;
      int                      waited;

      cfg_kind     = KIND_RESET;
      cfg_len      = BLOCK_RESET;
      pad_position = '0;
      pad_match    = 1'b1;
      pad_action   = 1'b0;

      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_action     <= 1'b0;
      req_hash_byte  <= '0;
      req_block_byte <= '0;
      csr_valid      <= 1'b0;
      csr_index      <= '0;
      csr_wdata      <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (i = 0; i < 22; i++) begin
         row = directed_cases[i];
         if (row.kind == ROW_WRITE) begin
            settle_block();
            write_register(row.reg_idx, row.reg_data);
         end else begin
            for (j = 0; j < int'(row.reps); j++) begin
               item.action     = row.action;
               item.hash_byte  = row.hash_byte;
               item.block_byte = row.follow ? frame_byte(pad_pos(), row.hash_byte)
                                            : row.block_byte;
               offer_request(item, row.typed, row.want);
            end
         end
      end

      for (phase = 0; random_items < RANDOM_ITEMS; phase++) begin
         settle_block();
         kind_data = CSR_DATA_W'($urandom);
         kind_data[KIND_W-1:0] = KIND_W'($urandom_range(0, 7));
         case ($urandom_range(0, 9))
            0: begin
               new_len = $urandom_range(0, 16);
            end
            1: begin
               new_len = $urandom_range(512, 1023);
            end
            2: begin
               new_len = frame_min(kind_data[KIND_W-1:0]) - int'($urandom_range(1, 5));
            end
            3: begin
               new_len = frame_min(kind_data[KIND_W-1:0]);
            end
            default: begin
               new_len = frame_min(kind_data[KIND_W-1:0]) + int'($urandom_range(0, 60));
            end
         endcase
         write_register(CSR_HASH_KIND, kind_data);
         write_register(CSR_BLOCK_BYTES, CSR_DATA_W'(new_len));
         blk = pad_len();
         if (blk > 200) begin
            n = $urandom_range(20, 80);
         end else begin
            n = blk - pad_pos() + blk * int'($urandom_range(0, 1));
            if ($urandom_range(0, 2) == 0) n += int'($urandom_range(1, blk - 1));
         end
         if (phase == 1) begin
            if (n < HOLD_OFF_ITEMS) n = HOLD_OFF_ITEMS;
            hold_off_req = 1'b1;
            wait (hold_off_active);
         end
         for (j = 0; j < n; j++) begin
            if (random_items >= QUIET_FROM) quiet_tail = 1'b1;
            if (pad_position == '0) begin
               case ($urandom_range(0, 9))
                  7, 8:    block_spoil = SPOIL_SPARSE;
                  9:       block_spoil = SPOIL_NOISE;
                  default: block_spoil = SPOIL_NONE;
               endcase
            end
            item.action    = ($urandom_range(0, 4) != 0);
            item.hash_byte = BYTE_W'($urandom_range(0, 255));
            good = frame_byte(pad_pos(), item.hash_byte);
            case (block_spoil)
               SPOIL_NONE: begin
                  item.block_byte = good;
               end
               SPOIL_SPARSE: begin
                  item.block_byte = ($urandom_range(0, 24) == 0) ?
                                    good ^ BYTE_W'($urandom_range(1, 255)) : good;
               end
               default: begin
                  item.block_byte = BYTE_W'($urandom_range(0, 255));
               end
            endcase
            offer_request(item, 1'b0, '0);
            random_items++;
         end
      end

      req_valid <= 1'b0;
      waited = 0;
      while (pending_rsp.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_rsp.size() != 0) begin
         report_mismatch($sformatf("%0d responses never arrived", pending_rsp.size()));
      end
      if (mismatch_count == 0) begin
         $display("pkcs1_v15_signature_padding_top test passed");
      end else begin
         $display("pkcs1_v15_signature_padding_top test failed");
      end
      $finish;
   end

   initial begin : watchdog
      #(2_000_000);
      $display("pkcs1_v15_signature_padding_top test failed");
      $finish;
   end

endmodule
